FILE: rtl/bsli_pkg.sv
package bsli_pkg;

  localparam int MAX_POINTS = 256;
  localparam int MAX_ATTRS  = 8;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PTR_W + 1;
  localparam int ATTR_W     = $clog2(MAX_ATTRS);
  localparam int NA_W       = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ATTRS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SORTED_MODE  = 1'd1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] ST_INTERP  = 3'd0;
  localparam logic [2:0] ST_EXACT   = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_NOT_INC = 3'd4;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key_value;
    logic signed [31:0] attr_in_0;
    logic signed [31:0] attr_in_1;
    logic signed [31:0] attr_in_2;
    logic signed [31:0] attr_in_3;
    logic signed [31:0] attr_in_4;
    logic signed [31:0] attr_in_5;
    logic signed [31:0] attr_in_6;
    logic signed [31:0] attr_in_7;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               dup_seen;
    logic signed [31:0] key_out;
    logic signed [31:0] attr_out_0;
    logic signed [31:0] attr_out_1;
    logic signed [31:0] attr_out_2;
    logic signed [31:0] attr_out_3;
    logic signed [31:0] attr_out_4;
    logic signed [31:0] attr_out_5;
    logic signed [31:0] attr_out_6;
    logic signed [31:0] attr_out_7;
  } out_word_t;

endpackage

FILE: rtl/bracket_search_linear_interp.sv
// Point store with bracketing search and linear interpolation. An append writes its
// attributes, one attribute memory write per cycle. A clear, or an ignored op, is done
// without leaving the idle state. A query first finds its bracket: the linear scan does
// one key memory read per cycle, the sorted search does its key reads as probes in
// sequence. It then does one attribute read per active attribute on an exact match, or,
// when interpolating, per active attribute two attribute reads, one 32x32 multiply, a
// 32-step restoring divide and one rounding step, and then posts the result word. The
// input is stalled until the query is finished; a finished result sits in the output
// register while the next word is taken. Stores have no reset and need no clearing pass.
module bracket_search_linear_interp import bsli_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_APP   = 14'b00000000000010,
    S_SCAN  = 14'b00000000000100,
    S_LB0   = 14'b00000000001000,
    S_LB    = 14'b00000000010000,
    S_LBEND = 14'b00000000100000,
    S_PAIR0 = 14'b00000001000000,
    S_PAIR1 = 14'b00000010000000,
    S_A0    = 14'b00000100000000,
    S_A1    = 14'b00001000000000,
    S_MUL   = 14'b00010000000000,
    S_DIV   = 14'b00100000000000,
    S_RND   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;
  logic   phase;

  logic [CNT_W-1:0] cnt;
  logic [NA_W-1:0]  active_attrs;
  logic             sorted_mode;
  logic [NA_W-1:0]  na;

  logic signed [31:0] point_keys  [MAX_POINTS];
  logic signed [31:0] point_attrs [MAX_POINTS*MAX_ATTRS];
  logic [PTR_W-1:0]        key_addr;
  logic [PTR_W+ATTR_W-1:0] attr_addr;
  logic signed [31:0]      key_q;
  logic signed [31:0]      attr_q;

  logic signed [31:0] abuf [MAX_ATTRS];
  logic [PTR_W-1:0]   slot;
  logic [ATTR_W-1:0]  wj;

  logic signed [31:0] v;
  logic [CNT_W-1:0]   scan_idx;
  logic               pvld;
  logic [PTR_W-1:0]   pidx;
  logic               h0;
  logic               h1;
  logic [PTR_W-1:0]   i0;
  logic [PTR_W-1:0]   i1;
  logic signed [31:0] k0;
  logic signed [31:0] k1;
  logic               dup;
  logic [PTR_W-1:0]   b;
  logic [CNT_W-1:0]   lim;

  logic [2:0]         res_status;
  logic signed [31:0] res_attr [MAX_ATTRS];
  logic [ATTR_W-1:0]  j;

  logic signed [31:0] a0;
  logic               neg;
  logic [31:0]        d;
  logic [31:0]        n;
  logic [31:0]        den;
  logic [31:0]        rem;
  logic [31:0]        quo;
  logic [4:0]         dcnt;

  logic               in_take;
  logic [CNT_W:0]     p_sum;
  logic [PTR_W-1:0]   p;
  logic [CNT_W:0]     lim_up;
  logic               j_last;
  state_t             attr_first;
  logic [32:0]        t_div;
  logic               t_ge;
  logic signed [32:0] diff;
  logic [33:0]        q_ext;
  logic signed [33:0] a0_ext;
  logic signed [33:0] lo_base;
  logic signed [33:0] lo_fin;
  logic               gt;
  logic               tie;
  logic               issue;
  logic               k_le;
  logic               post;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  assign na = (active_attrs > NA_W'(MAX_ATTRS)) ? NA_W'(MAX_ATTRS) : active_attrs;

  // Probe point of the lower-bound search, clamped to the last stored point.
  assign p_sum  = (CNT_W+1)'(b) + (CNT_W+1)'(lim >> 1);
  assign p      = (p_sum >= (CNT_W+1)'(cnt)) ? PTR_W'(cnt - CNT_W'(1)) : p_sum[PTR_W-1:0];
  assign lim_up = ((CNT_W+1)'(lim) + (CNT_W+1)'(1)) >> 1;

  assign j_last     = ((NA_W'(j) + NA_W'(1)) >= na);
  assign attr_first = (na == '0) ? S_DONE : S_A0;

  assign issue = (scan_idx < cnt);
  assign k_le  = (key_q <= v);

  assign t_div = {rem, quo[31]};
  assign t_ge  = (t_div >= {1'b0, den});
  assign diff  = {attr_q[31], attr_q} - {a0[31], a0};

  // Round to nearest, ties away from zero.
  assign q_ext   = {2'b00, quo};
  assign a0_ext  = {{2{a0[31]}}, a0};
  assign lo_base = neg ? (a0_ext - signed'(q_ext)) : (a0_ext + signed'(q_ext));
  assign gt      = ({rem, 1'b0} > {1'b0, den});
  assign tie     = ({rem, 1'b0} == {1'b0, den});

  assign post = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    lo_fin = lo_base;
    if (!neg) begin
      if (gt || (tie && !lo_base[33])) begin
        lo_fin = lo_base + 34'sd1;
      end
    end else begin
      if (gt || (tie && (lo_base[33] || lo_base == '0))) begin
        lo_fin = lo_base - 34'sd1;
      end
    end
  end

  always_comb begin
    case (state)
      S_SCAN:  key_addr = scan_idx[PTR_W-1:0];
      S_LB:    key_addr = p;
      S_PAIR0: key_addr = i0;
      S_PAIR1: key_addr = i0 + PTR_W'(1);
      default: key_addr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_A1:    attr_addr = {i1, j};
      default: attr_addr = {i0, j};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take && in_data.op == OP_APPEND && cnt < CNT_W'(MAX_POINTS)) begin
      point_keys[cnt[PTR_W-1:0]] <= in_data.key_value;
    end
    key_q <= point_keys[key_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_APP) begin
      point_attrs[{slot, wj}] <= abuf[wj];
    end
    attr_q <= point_attrs[attr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_attrs <= NA_W'(MAX_ATTRS);
      sorted_mode  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_ATTRS: active_attrs <= cfg_data[NA_W-1:0];
        CFG_SORTED_MODE:  sorted_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (post) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          phase <= 1'b0;
          if (in_take) begin
            case (in_data.op)
              OP_CLEAR: begin
                cnt <= '0;
              end
              OP_APPEND: begin
                if (cnt < CNT_W'(MAX_POINTS)) begin
                  slot    <= cnt[PTR_W-1:0];
                  wj      <= '0;
                  abuf[0] <= in_data.attr_in_0;
                  abuf[1] <= in_data.attr_in_1;
                  abuf[2] <= in_data.attr_in_2;
                  abuf[3] <= in_data.attr_in_3;
                  abuf[4] <= in_data.attr_in_4;
                  abuf[5] <= in_data.attr_in_5;
                  abuf[6] <= in_data.attr_in_6;
                  abuf[7] <= in_data.attr_in_7;
                  cnt     <= cnt + CNT_W'(1);
                  state   <= S_APP;
                end
              end
              OP_QUERY: begin
                v        <= in_data.key_value;
                dup      <= 1'b0;
                h0       <= 1'b0;
                h1       <= 1'b0;
                i0       <= '0;
                i1       <= '0;
                j        <= '0;
                scan_idx <= '0;
                pvld     <= 1'b0;
                for (int e = 0; e < MAX_ATTRS; e++) begin
                  res_attr[e] <= '0;
                end
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else if (sorted_mode) begin
                  state <= S_LB0;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        S_APP: begin
          wj <= wj + ATTR_W'(1);
          if (wj == ATTR_W'(MAX_ATTRS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (issue) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          pvld <= issue;
          pidx <= scan_idx[PTR_W-1:0];
          if (pvld) begin
            if (k_le) begin
              if (h0 && key_q == k0) begin
                dup <= 1'b1;
              end
              if (!h0 || key_q > k0) begin
                i0 <= pidx;
                k0 <= key_q;
                h0 <= 1'b1;
              end
            end else begin
              if (h1 && key_q == k1) begin
                dup <= 1'b1;
              end
              if (!h1 || key_q < k1) begin
                i1 <= pidx;
                k1 <= key_q;
                h1 <= 1'b1;
              end
            end
          end
          if (!issue && !pvld) begin
            if (!h0 || !h1) begin
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              res_status <= (v == k0) ? ST_EXACT : ST_INTERP;
              state      <= attr_first;
            end
          end
        end

        S_LB0: begin
          phase <= !phase;
          if (phase) begin
            if (v < key_q) begin
              res_status <= ST_RANGE;
              state      <= S_DONE;
            end else begin
              b     <= '0;
              lim   <= cnt;
              state <= S_LB;
            end
          end
        end

        S_LB: begin
          if (!phase) begin
            if (lim <= CNT_W'(1)) begin
              i0    <= b;
              state <= S_LBEND;
            end else begin
              phase <= 1'b1;
            end
          end else begin
            phase <= 1'b0;
            if (v == key_q) begin
              i0    <= p;
              state <= S_LBEND;
            end else if (v > key_q) begin
              b   <= p;
              lim <= lim_up[CNT_W-1:0];
            end else begin
              lim <= lim >> 1;
            end
          end
        end

        S_LBEND: begin
          if ((CNT_W'(i0) + CNT_W'(1)) >= cnt) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_PAIR0;
          end
        end

        S_PAIR0: begin
          phase <= !phase;
          if (phase) begin
            k0    <= key_q;
            state <= S_PAIR1;
          end
        end

        S_PAIR1: begin
          phase <= !phase;
          if (phase) begin
            k1 <= key_q;
            i1 <= i0 + PTR_W'(1);
            if (!(k0 <= v && v < key_q)) begin
              res_status <= ST_NOT_INC;
              state      <= S_DONE;
            end else begin
              res_status <= (v == k0) ? ST_EXACT : ST_INTERP;
              state      <= attr_first;
            end
          end
        end

        S_A0: begin
          phase <= !phase;
          if (phase) begin
            if (res_status == ST_EXACT) begin
              res_attr[j] <= attr_q;
              j <= j + ATTR_W'(1);
              if (j_last) begin
                state <= S_DONE;
              end
            end else begin
              a0    <= attr_q;
              state <= S_A1;
            end
          end
        end

        S_A1: begin
          phase <= !phase;
          if (phase) begin
            neg   <= diff[32];
            d     <= diff[32] ? 32'(-diff) : diff[31:0];
            n     <= 32'(v - k0);
            den   <= 32'(k1 - k0);
            state <= S_MUL;
          end
        end

        S_MUL: begin
          {rem, quo} <= 64'(n) * 64'(d);
          dcnt       <= '0;
          state      <= S_DIV;
        end

        // One quotient bit per cycle; the high product half is already below den.
        S_DIV: begin
          rem  <= t_ge ? 32'(t_div - {1'b0, den}) : t_div[31:0];
          quo  <= {quo[30:0], t_ge};
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) begin
            state <= S_RND;
          end
        end

        S_RND: begin
          res_attr[j] <= lo_fin[31:0];
          j <= j + ATTR_W'(1);
          state <= j_last ? S_DONE : S_A0;
        end

        S_DONE: begin
          if (post) begin
            out_data.status     <= res_status;
            out_data.dup_seen   <= dup;
            out_data.key_out    <= v;
            out_data.attr_out_0 <= res_attr[0];
            out_data.attr_out_1 <= res_attr[1];
            out_data.attr_out_2 <= res_attr[2];
            out_data.attr_out_3 <= res_attr[3];
            out_data.attr_out_4 <= res_attr[4];
            out_data.attr_out_5 <= res_attr[5];
            out_data.attr_out_6 <= res_attr[6];
            out_data.attr_out_7 <= res_attr[7];
            state               <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_POINTS))
    else $error("point count above store depth");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0 && rem < den))
    else $error("divider remainder out of range");

  a_sorted_nodup: assert property (@(posedge clk) disable iff (rst)
    (state == S_LB) |-> !dup)
    else $error("duplicate flag set during sorted search");

  a_rnd_interp: assert property (@(posedge clk) disable iff (rst)
    (state == S_RND) |-> (res_status == ST_INTERP))
    else $error("rounding step on a non-interpolated query");

  a_done_post: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished word not posted");

endmodule

FILE: test/bracket_search_linear_interp_test.sv
`timescale 1ns / 1ps

module bracket_search_linear_interp_test;
  import bsli_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         SETTLE       = 32;
  localparam int         RANDOM_WORDS = 400;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint     KEY_MAX      = 64'sd2147483647;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

  typedef struct {
    bit                    cfg_row;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    in_word_t              word;
    bit                    typed;
    out_word_t             want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // copy of the point store and the registers
  logic signed [31:0] store_key [MAX_POINTS];
  logic signed [31:0] store_attr [MAX_POINTS][MAX_ATTRS];
  int unsigned        store_count = 0;
  logic [3:0]         cfg_active = 4'd8;
  logic               cfg_sorted = 1'b0;

  out_word_t   pending_lookups[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          calm = 1'b0;

  bracket_search_linear_interp i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // a0 + n*(a1-a0)/den, rounded to nearest with ties away from zero
  function automatic logic [31:0] round_lerp(longint a0, longint a1,
                                             longint unsigned n, longint unsigned den);
    longint unsigned d, prod, q, rem;
    longint s, lo;
    if (a1 >= a0) begin
      d = a1 - a0;
      s = 1;
    end else begin
      d = a0 - a1;
      s = -1;
    end
    prod = n * d;
    q = prod / den;
    rem = prod % den;
    lo = a0 + s * $signed(q);
    if (2 * rem > den) begin
      lo = lo + s;
    end else if (2 * rem == den) begin
      if (2 * lo + s > 0) begin
        if (s > 0) lo = lo + 1;
      end else begin
        if (s < 0) lo = lo - 1;
      end
    end
    return lo[31:0];
  endfunction

  function automatic out_word_t lookup_result(logic signed [31:0] v);
    out_word_t   r;
    int unsigned na, i, j, i0, i1, b, lim, p;
    bit          h0, h1, found, done;
    longint      k0, k1, n, den;
    r = '0;
    r.key_out = v;
    na = (cfg_active > MAX_ATTRS) ? MAX_ATTRS : cfg_active;
    i0 = 0;
    i1 = 0;
    h0 = 1'b0;
    h1 = 1'b0;
    if (store_count == 0) begin
      r.status = ST_EMPTY;
    end else if (cfg_sorted) begin
      found = (v >= store_key[0]);
      done = 1'b0;
      b = 0;
      lim = store_count;
      while (found && lim > 1 && !done) begin
        p = b + (lim >> 1);
        if (p >= store_count) p = store_count - 1;
        if (v == store_key[p]) begin
          i0 = p;
          done = 1'b1;
        end else begin
          if (v > store_key[p]) begin
            b = p;
            lim++;
          end
          lim = lim >> 1;
        end
      end
      if (!done) i0 = b;
      if (!found || i0 + 1 >= store_count) begin
        r.status = ST_RANGE;
      end else begin
        i1 = i0 + 1;
        if (!(store_key[i0] <= v && v < store_key[i1])) r.status = ST_NOT_INC;
        else r.status = (v == store_key[i0]) ? ST_EXACT : ST_INTERP;
      end
    end else begin
      for (i = 0; i < store_count; i++) begin
        if (store_key[i] <= v) begin
          if (h0 && store_key[i] == store_key[i0]) r.dup_seen = 1'b1;
          if (!h0 || store_key[i] > store_key[i0]) begin
            i0 = i;
            h0 = 1'b1;
          end
        end else begin
          if (h1 && store_key[i] == store_key[i1]) r.dup_seen = 1'b1;
          if (!h1 || store_key[i] < store_key[i1]) begin
            i1 = i;
            h1 = 1'b1;
          end
        end
      end
      if (!h0 || !h1) r.status = ST_RANGE;
      else r.status = (v == store_key[i0]) ? ST_EXACT : ST_INTERP;
    end
    if (r.status == ST_EXACT) begin
      for (j = 0; j < na; j++) r[32*(MAX_ATTRS-1-j) +: 32] = store_attr[i0][j];
    end else if (r.status == ST_INTERP) begin
      k0 = store_key[i0];
      k1 = store_key[i1];
      n = longint'(v) - k0;
      den = k1 - k0;
      for (j = 0; j < na; j++) begin
        r[32*(MAX_ATTRS-1-j) +: 32] =
          round_lerp(store_attr[i0][j], store_attr[i1][j], n, den);
      end
    end
    return r;
  endfunction

  function automatic void advance_store(in_word_t w);
    int unsigned j;
    if (w.op == OP_CLEAR) begin
      store_count = 0;
    end else if (w.op == OP_APPEND && store_count < MAX_POINTS) begin
      store_key[store_count] = w.key_value;
      for (j = 0; j < MAX_ATTRS; j++) store_attr[store_count][j] = w[32*(MAX_ATTRS-1-j) +: 32];
      store_count++;
    end
  endfunction

  function automatic in_word_t make_word(logic [1:0] op, logic [31:0] key);
    in_word_t    w;
    int unsigned j;
    w = '0;
    w.op = op;
    w.key_value = key;
    for (j = 0; j < MAX_ATTRS; j++) w[32*(MAX_ATTRS-1-j) +: 32] = $urandom;
    return w;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.cfg_row = 1'b1;
    r.reg_index = idx;
    r.reg_value = val;
    r.word = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // attribute j of the point is base + j*step
  function automatic plan_row_t point_row(logic [1:0] op, logic [31:0] key,
                                          logic [31:0] base, logic [31:0] step);
    plan_row_t   r;
    int unsigned j;
    r = reg_row('0, '0);
    r.cfg_row = 1'b0;
    r.word.op = op;
    r.word.key_value = key;
    for (j = 0; j < MAX_ATTRS; j++) r.word[32*(MAX_ATTRS-1-j) +: 32] = base + j * step;
    return r;
  endfunction

  function automatic plan_row_t known_query(logic [31:0] key, logic [2:0] st,
                                            logic [31:0] fill, int unsigned n);
    plan_row_t   r;
    int unsigned j;
    r = point_row(OP_QUERY, key, '0, '0);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.key_out = key;
    for (j = 0; j < n; j++) r.want[32*(MAX_ATTRS-1-j) +: 32] = fill;
    return r;
  endfunction

  function automatic logic [31:0] pick_query_key();
    logic signed [31:0] a, b;
    if (store_count == 0) return $urandom;
    a = store_key[$urandom_range(0, store_count - 1)];
    b = store_key[$urandom_range(0, store_count - 1)];
    case ($urandom_range(0, 5))
      0: return a;
      1: return a + 1;
      2: return a - 1;
      3: return 32'((longint'(a) + longint'(b)) / 2);
      4: return $urandom;
      default: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (w.op == OP_QUERY) pending_lookups.push_back(typed ? want : lookup_result(w.key_value));
    else advance_store(w);
    if (w.op != OP_UNUSED) words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(logic [1:0] op, logic [31:0] key);
    send_word(make_word(op, key), 1'b0, '0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    // an append may still be in flight
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE_ATTRS) cfg_active = val;
    else cfg_sorted = val[0];
  endtask

  task automatic run_phase(bit fill_store);
    int unsigned npts, nq, style, span, i;
    longint      k;
    logic [3:0]  na_pick;
    calm = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 4))
      0: na_pick = 4'd0;
      1: na_pick = 4'd1;
      2: na_pick = 4'd8;
      3: na_pick = 4'd15;
      default: na_pick = 4'($urandom_range(1, 15));
    endcase
    write_reg(CFG_ACTIVE_ATTRS, na_pick);
    write_reg(CFG_SORTED_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    send_random(OP_CLEAR, $urandom);
    npts = fill_store ? MAX_POINTS + 2 : $urandom_range(0, 12);
    // style 0 rising keys, 1 keys anywhere, 2 narrow keys with repeats
    if (fill_store) style = 0;
    else if (cfg_sorted) style = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    else style = $urandom_range(0, 2);
    span = fill_store ? 16 : (1 << $urandom_range(0, 24));
    if ($urandom_range(0, 1)) k = longint'($signed($urandom));
    else k = longint'($urandom_range(0, 2000)) - 1000;
    for (i = 0; i < npts; i++) begin
      if (style == 0 && k > KEY_MAX) break;
      if (style == 0) send_random(OP_APPEND, k[31:0]);
      else if (style == 1) send_random(OP_APPEND, $urandom);
      else send_random(OP_APPEND, $urandom_range(0, 20));
      k = k + $urandom_range(1, span);
      if ($urandom_range(0, 15) == 0) send_random(OP_UNUSED, $urandom);
    end
    nq = $urandom_range(2, 10);
    for (i = 0; i < nq; i++) begin
      case ($urandom_range(0, 11))
        0: send_random(OP_UNUSED, $urandom);
        1: send_random(OP_APPEND, $urandom);
        default: ;
      endcase
      send_random(OP_QUERY, pick_query_key());
    end
  endtask

  always @(negedge clk) begin
    if (out_valid === 1'b1 && hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t   want;
    int unsigned j;
    if (!rst && out_valid && !out_stall) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: result word with none expected: %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("dup_seen", want.dup_seen, out_data.dup_seen);
        check_field("key_out", want.key_out, out_data.key_out);
        for (j = 0; j < MAX_ATTRS; j++) begin
          check_field($sformatf("attr_out_%0d", j), want[32*(MAX_ATTRS-1-j) +: 32],
                      out_data[32*(MAX_ATTRS-1-j) +: 32]);
        end
      end
      hold_left = calm ? 0 : $urandom_range(0, 16);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bracket_search_linear_interp] ERROR");
      $finish;
    end
  end

  initial begin
    plan_row_t   directed_plan[$];
    int unsigned phase_no, random_target;
    directed_plan.push_back(known_query(32'sd5, ST_EMPTY, '0, 0));
    directed_plan.push_back(point_row(OP_UNUSED, S32_MAX, S32_MIN, 32'd1));
    directed_plan.push_back(point_row(OP_APPEND, -32'sd100, S32_MIN, '0));
    directed_plan.push_back(point_row(OP_APPEND, 32'sd100, S32_MAX, '0));
    directed_plan.push_back(known_query(32'sd0, ST_INTERP, '0, 0));
    directed_plan[$].typed = 1'b0;
    directed_plan.push_back(known_query(-32'sd100, ST_EXACT, S32_MIN, MAX_ATTRS));
    directed_plan.push_back(known_query(-32'sd101, ST_RANGE, '0, 0));
    directed_plan.push_back(known_query(32'sd100, ST_RANGE, '0, 0));
    directed_plan.push_back(reg_row(CFG_ACTIVE_ATTRS, 4'd3));
    directed_plan.push_back(known_query(-32'sd100, ST_EXACT, S32_MIN, 3));
    directed_plan.push_back(reg_row(CFG_ACTIVE_ATTRS, 4'd0));
    directed_plan.push_back(known_query(32'sd0, ST_INTERP, '0, 0));
    directed_plan.push_back(reg_row(CFG_ACTIVE_ATTRS, 4'd15));
    // repeated upper key: the scan flags it
    directed_plan.push_back(point_row(OP_APPEND, 32'sd100, 32'sd7, 32'sd1));
    directed_plan.push_back(known_query(32'sd50, ST_INTERP, '0, 0));
    directed_plan[$].typed = 1'b0;
    directed_plan.push_back(reg_row(CFG_SORTED_MODE, 4'd1));
    directed_plan.push_back(known_query(32'sd100, ST_INTERP, '0, 0));
    directed_plan[$].typed = 1'b0;
    directed_plan.push_back(known_query(-32'sd200, ST_RANGE, '0, 0));
    directed_plan.push_back(known_query(S32_MAX, ST_INTERP, '0, 0));
    directed_plan[$].typed = 1'b0;
    directed_plan.push_back(point_row(OP_CLEAR, S32_MIN, S32_MAX, '0));
    directed_plan.push_back(known_query(32'sd0, ST_EMPTY, '0, 0));
    // halfway between 0 and odd attributes: ties round away from zero
    directed_plan.push_back(point_row(OP_APPEND, 32'sd0, '0, '0));
    directed_plan.push_back(point_row(OP_APPEND, 32'sd2, -32'sd3, 32'sd2));
    directed_plan.push_back(known_query(32'sd1, ST_INTERP, '0, 0));
    directed_plan[$].typed = 1'b0;
    // search ending on the last point
    directed_plan.push_back(known_query(32'sd2, ST_RANGE, '0, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].cfg_row) begin
        write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
      end else begin
        send_word(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    random_target = words_sent + RANDOM_WORDS;
    phase_no = 0;
    while (words_sent < random_target) begin
      run_phase(phase_no == 2);
      phase_no++;
    end

    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (mismatches == 0) begin
      $display("[bracket_search_linear_interp] OK");
    end else begin
      $display("[bracket_search_linear_interp] ERROR");
    end
    $finish;
  end

endmodule
